>>> design/escaped_packet_deframer_crc16_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packet deframer checker
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_PACKET_DEFRAMER_CRC16_CORE_DEFINES_SVH
`define ESCAPED_PACKET_DEFRAMER_CRC16_CORE_DEFINES_SVH

// same-cycle implication
`define EPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed (same cycle)");

// next-cycle implication
`define EPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed (next cycle)");

`endif

>>> design/epdcrc_pkg.sv
// ----------------------------------------------------------------------------
// epdcrc_pkg
// Types and codes shared by the deframer controller, datapath and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package epdcrc_pkg;

  // line codes
  localparam logic [7:0] CODE_NUL   = 8'h00;
  localparam logic [7:0] CODE_SYN   = 8'h16;
  localparam logic [7:0] CODE_STX   = 8'h02;
  localparam logic [7:0] CODE_ETX   = 8'h03;
  localparam logic [7:0] CODE_ESC   = 8'h1B;
  localparam logic [7:0] ESC_OFFSET = 8'h40;

  // operations and result kinds
  localparam logic OP_LINE     = 1'b0;
  localparam logic OP_READ     = 1'b1;
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LIMIT_W    = 9;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLYNOMIAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_INITIAL    = 2'd2;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 9'd256;
  localparam logic [15:0]          POLY_RESET  = 16'h1021;
  localparam logic [15:0]          INIT_RESET  = 16'h1D0F;

  // byte classes
  localparam int CLS_W = 3;
  localparam logic [CLS_W-1:0] CLS_IGNORE = 3'd0;
  localparam logic [CLS_W-1:0] CLS_STX    = 3'd1;
  localparam logic [CLS_W-1:0] CLS_ETX    = 3'd2;
  localparam logic [CLS_W-1:0] CLS_ESC    = 3'd3;
  localparam logic [CLS_W-1:0] CLS_DATA   = 3'd4;

  typedef struct packed {
    logic       operation;
    logic [7:0] line_byte;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] packet_length;
    logic [7:0] read_data;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic store_wr;
    logic unescape;
    logic cnt_clear;
    logic crc_load;
    logic rd_en;
    logic emit_pkt;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CLS_W-1:0] byte_class;
    logic             full;
    logic             ge2;
    logic             crc_match;
  } stat_t;

endpackage

`default_nettype wire

>>> design/epdcrc_ctrl.sv
// ----------------------------------------------------------------------------
// epdcrc_ctrl
// Frame state machine: hunt for STX / receive, escape mark, command decode.
// ----------------------------------------------------------------------------
`default_nettype none

module epdcrc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire                 in_operation,
  input  epdcrc_pkg::stat_t   status,
  output epdcrc_pkg::cmd_t    cmd,
  output logic                busy
);
  import epdcrc_pkg::*;

  localparam logic ST_HUNT = 1'b0;
  localparam logic ST_RECV = 1'b1;

  logic state_r, state_nxt;
  logic esc_r, esc_nxt;
  logic busy_r;
  logic accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    esc_nxt   = esc_r;
    if (accept) begin
      if (in_operation == OP_READ) begin
        cmd.rd_en = 1'b1;
      end else begin
        case (status.byte_class)
          CLS_STX: begin
            state_nxt     = ST_RECV;
            esc_nxt       = 1'b0;
            cmd.cnt_clear = 1'b1;
            cmd.crc_load  = 1'b1;
          end
          CLS_ESC: begin
            esc_nxt = 1'b1;
          end
          CLS_ETX: begin
            state_nxt     = ST_HUNT;
            cmd.cnt_clear = 1'b1;
            cmd.emit_pkt  = (state_r == ST_RECV) && status.ge2 && status.crc_match;
          end
          CLS_DATA: begin
            if (state_r == ST_RECV) begin
              if (status.full) begin
                // overflow: drop the packet, escape mark untouched
                state_nxt     = ST_HUNT;
                cmd.cnt_clear = 1'b1;
              end else begin
                cmd.store_wr = 1'b1;
                cmd.unescape = esc_r;
                esc_nxt      = 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      esc_r   <= 1'b0;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      esc_r   <= esc_nxt;
      busy_r  <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> design/epdcrc_dp.sv
// ----------------------------------------------------------------------------
// epdcrc_dp
// Datapath: config registers, byte classifier, packet store, running CRC,
// two-byte history and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module epdcrc_dp #(
  parameter int STORE_DEPTH = 256
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        cfg_we,
  input  wire  [epdcrc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire  [epdcrc_pkg::CFG_DATA_W-1:0]          cfg_wdata,
  input  epdcrc_pkg::in_item_t                       in_item,
  input  epdcrc_pkg::cmd_t                           cmd,
  output epdcrc_pkg::stat_t                          status,
  output logic                                       out_valid,
  output epdcrc_pkg::out_item_t                      out_item
);
  import epdcrc_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int RW    = (AW > 8) ? AW : 8;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [7:0]  b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // config
  logic [LIMIT_W-1:0] limit_r;
  logic [15:0]        poly_r;
  logic [15:0]        init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      poly_r  <= POLY_RESET;
      init_r  <= INIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUFFER_LIMIT:   limit_r <= cfg_wdata[LIMIT_W-1:0];
        REG_CRC_POLYNOMIAL: poly_r  <= cfg_wdata[15:0];
        REG_CRC_INITIAL:    init_r  <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // byte class
  logic [CLS_W-1:0] byte_class;
  always_comb begin
    case (in_item.line_byte)
      CODE_NUL, CODE_SYN: byte_class = CLS_IGNORE;
      CODE_STX:           byte_class = CLS_STX;
      CODE_ETX:           byte_class = CLS_ETX;
      CODE_ESC:           byte_class = CLS_ESC;
      default:            byte_class = CLS_DATA;
    endcase
  end

  // count, CRC, history
  logic [CNT_W-1:0] cnt_r;
  logic [15:0]      crc_r;
  logic [7:0]       hist0_r, hist1_r;   // bytes at cnt-2 and cnt-1
  logic [7:0]       data_byte;
  logic             ge2, full;

  assign data_byte = cmd.unescape ? (in_item.line_byte - ESC_OFFSET) : in_item.line_byte;
  assign ge2  = cnt_r >= CNT_W'(2);
  assign full = (CMP_W'(cnt_r) >= CMP_W'(limit_r)) || (cnt_r == CNT_W'(STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      crc_r <= INIT_RESET;
    end else begin
      if (cmd.cnt_clear) begin
        cnt_r <= '0;
      end else if (cmd.store_wr) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.crc_load) begin
        crc_r <= init_r;
      end else if (cmd.store_wr && ge2) begin
        crc_r <= crc_fold(crc_r, hist0_r, poly_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      hist0_r <= hist1_r;
      hist1_r <= data_byte;
    end
  end

  assign status.byte_class = byte_class;
  assign status.full       = full;
  assign status.ge2        = ge2;
  assign status.crc_match  = ({hist1_r, hist0_r} == crc_r);

  // packet store
  logic [7:0]    mem [STORE_DEPTH];
  logic [7:0]    mem_q_r;
  logic [RW-1:0] idx_w;
  logic          oob;

  assign idx_w = RW'(in_item.read_index);
  assign oob   = {1'b0, idx_w} >= (RW+1)'(STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      mem[cnt_r[AW-1:0]] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      mem_q_r <= mem[idx_w[AW-1:0]];
    end
  end

  // result register
  logic [CMP_W-1:0] len_full;
  logic             out_valid_r;
  logic             kind_r;
  logic [7:0]       len_r;
  logic             oob_r;

  assign len_full = CMP_W'(cnt_r) - CMP_W'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.rd_en || cmd.emit_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en || cmd.emit_pkt) begin
      kind_r <= cmd.rd_en ? KIND_READ : KIND_PACKET;
      len_r  <= cmd.rd_en ? 8'h00 : len_full[7:0];
      oob_r  <= oob;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_item.result_kind   = kind_r;
  assign out_item.packet_length = len_r;
  assign out_item.read_data     = (kind_r == KIND_READ && !oob_r) ? mem_q_r : 8'h00;

endmodule

`default_nettype wire

>>> design/escaped_packet_deframer_crc16_core.sv
// ----------------------------------------------------------------------------
// escaped_packet_deframer_crc16_core
// STX/ETX byte-stuffed deframer with a running CRC-16 check and a readable
// packet store.
// ----------------------------------------------------------------------------
//
//  channel  | ports                           | handshake
//  ---------+---------------------------------+------------------------------
//  input    | start, busy, in_item            | item taken when start && !busy
//  result   | out_valid, out_item             | one-cycle strobe, no backpressure
//  config   | cfg_we, cfg_index, cfg_wdata    | write on cfg_we, no wait
//
//  One item per cycle while busy is low. Each result (good packet length
//  or read data) shows in the cycle after its item, for exactly one cycle.
//  The byte-wide CRC fold and the store write both finish in the accept
//  cycle; a read goes through the store's registered read port.
//  busy is high only in the first cycle out of reset; the store needs no
//  clearing pass. The receiver cannot stall, so nothing else holds busy.
//
//  Structure: epdcrc_ctrl tracks framing (hunting for STX or receiving)
//  and the escape mark and issues commands; epdcrc_dp holds the store, the
//  byte counter, the CRC lagging two bytes behind the write position, a
//  two-byte history of the last stored bytes (the CRC bytes at ETX), and
//  the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_packet_deframer_crc16_core #(
  parameter int STORE_DEPTH = 256
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  epdcrc_pkg::in_item_t               in_item,
  output logic                               out_valid,
  output epdcrc_pkg::out_item_t              out_item,
  input  wire                                cfg_we,
  input  wire  [epdcrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [epdcrc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import epdcrc_pkg::*;

  cmd_t  cmd;
  stat_t status;

  // framing control
  epdcrc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_item.operation),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  // store, CRC and result register
  epdcrc_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> design/epdcrc_chk.sv
// ----------------------------------------------------------------------------
// epdcrc_chk
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "escaped_packet_deframer_crc16_core_defines.svh"

module epdcrc_chk (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                start,
  input wire                                busy,
  input epdcrc_pkg::in_item_t               in_item,
  input wire                                out_valid,
  input epdcrc_pkg::out_item_t              out_item
);
  import epdcrc_pkg::*;

  logic take;
  logic take_read;
  logic take_plain;
  logic fields_ok;

  assign take       = start && !busy;
  assign take_read  = take && in_item.operation == OP_READ;
  assign take_plain = take && in_item.operation == OP_LINE && in_item.line_byte != CODE_ETX;
  assign fields_ok  = (out_item.result_kind == KIND_PACKET && out_item.read_data == 8'h00) ||
                      (out_item.result_kind == KIND_READ && out_item.packet_length == 8'h00);

  // every result follows an accepted item
  `EPD_ASSERT_IMPL(a_result_has_cause, out_valid, $past(take))

  // a read always answers in the next cycle
  `EPD_ASSERT_NEXT(a_read_answers, take_read, out_valid && out_item.result_kind == KIND_READ)

  // only ETX can complete a packet
  `EPD_ASSERT_NEXT(a_no_result_from_line, take_plain, !out_valid)

  // unused field of each result kind is zero
  `EPD_ASSERT_IMPL(a_unused_field_zero, out_valid, fields_ok)

endmodule

bind escaped_packet_deframer_crc16_core epdcrc_chk u_chk (.*);

`default_nettype wire
